@@ rtl/chained_name_hash_table_core_defines.svh @@
// assertion macros for the chained name hash table
// expects clk and rst_n in the scope of each use
`ifndef CHAINED_NAME_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_NAME_HASH_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CNHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CNHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CNHT_ASSERT_IMP(lbl, ante, cons, msg)
`define CNHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/cnht_pkg.sv @@
// shared types, codes and helpers for the chained name hash table
// no dependencies
`default_nettype none
package cnht_pkg;

    localparam int BUCKET_DEPTH = 4096;
    localparam int BUCKET_AW    = 12;
    localparam int CFG_W        = 13;
    localparam int IDX_W        = 12;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] entry_name;
    } cnht_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] entry_index;
    } cnht_out_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_BUCKET,
        ST_HEAD,
        ST_WALK,
        ST_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        BU_IDLE,
        BU_HASH,
        BU_DIV,
        BU_DONE
    } bu_state_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
            r = c - 8'h20;
        return r;
    endfunction

    function automatic logic names_match(input logic [63:0] a, input logic [63:0] b);
        logic       res;
        logic       stop;
        logic [7:0] x;
        logic [7:0] y;
        res  = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            x = fold_byte(a[8*k +: 8]);
            y = fold_byte(b[8*k +: 8]);
            if (!stop)
            begin
                if (x != y)
                begin
                    res  = 1'b0;
                    stop = 1'b1;
                end
                else if (x == 8'h00)
                begin
                    stop = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ rtl/chained_name_hash_table_core.sv @@
// top level of the chained name hash table: sequencer, bucket heads, links, names
// depends on cnht_pkg, cnht_bucket_unit and the assertion macro header
`default_nettype none
`include "chained_name_hash_table_core_defines.svh"
// Keeps up to MAX_ENTRIES 8-byte names in chained hash buckets and takes one word at
// a time. An insert runs the byte-serial hash and then the bit-serial modulo in the
// bucket unit, reads the bucket head and links the new entry in at the chain front.
// A lookup does the same up to the head read and then walks the chain, each node one
// registered read of the link and name memories. A clear and the pass after reset each
// sweep the 4096 bucket heads one per cycle with input stalled; config writes are
// taken at any time. A result waits in an output register, so the next word is
// accepted while it is still stalled.
module chained_name_hash_table_core #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  cnht_pkg::cnht_in_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output cnht_pkg::cnht_out_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cnht_pkg::CFG_W-1:0]   cfg_data
);
    import cnht_pkg::*;

    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic [LW-1:0] NO_ENTRY = LW'(MAX_ENTRIES);

    top_state_t           state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [LW-1:0]        cnt_reg, cnt_next;
    logic [BUCKET_AW-1:0] sweep_reg, sweep_next;
    logic                 reply_reg, reply_next;
    logic [1:0]           act_reg, act_next;
    logic [63:0]          name_reg, name_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic                 out_valid_reg, out_valid_next;
    cnht_out_t            out_data_reg, out_data_next;

    logic [LW-1:0]        head_mem [BUCKET_DEPTH];
    logic [LW-1:0]        link_mem [MAX_ENTRIES];
    logic [63:0]          name_mem [MAX_ENTRIES];
    logic [LW-1:0]        head_q;
    logic [LW-1:0]        link_q;
    logic [63:0]          name_q;

    logic                 head_we;
    logic [BUCKET_AW-1:0] head_wa;
    logic [LW-1:0]        head_wd;
    logic                 ent_we;
    logic [AW-1:0]        rd_addr;

    logic                 accept;
    logic                 full;
    logic                 bu_start;
    logic                 bu_done;
    logic [BUCKET_AW-1:0] bucket;
    logic [CFG_W-1:0]     divisor;
    logic                 hit;
    logic                 leave_done;
    logic [31:0]          cnt_wide;
    logic [31:0]          cur_wide;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign full       = (cnt_reg == NO_ENTRY);
    assign bu_start   = accept && ((in_data.action == ACT_LOOKUP) ||
                                   (in_data.action == ACT_INSERT && !full));
    assign hit        = names_match(name_q, name_reg);
    assign leave_done = !out_valid_reg || !out_stall;
    assign cnt_wide   = 32'(cnt_reg);
    assign cur_wide   = 32'(cur_reg);
    assign rd_addr    = (state_reg == ST_HEAD) ? head_q[AW-1:0] : link_q[AW-1:0];

    // zero reads as one bucket, anything past the head table as all of it
    always_comb
    begin
        if (cfg_reg == '0)
            divisor = CFG_W'(1);
        else if (cfg_reg > CFG_W'(BUCKET_DEPTH))
            divisor = CFG_W'(BUCKET_DEPTH);
        else
            divisor = cfg_reg;
    end

    cnht_bucket_unit u_bucket (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (bu_start),
        .name    (in_data.entry_name),
        .divisor (divisor),
        .done    (bu_done),
        .bucket  (bucket)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
                if (sweep_reg == BUCKET_AW'(BUCKET_DEPTH - 1))
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.action)
                        ACT_INSERT: state_next = full ? ST_DONE : ST_BUCKET;
                        ACT_LOOKUP: state_next = ST_BUCKET;
                        ACT_CLEAR:  state_next = ST_SWEEP;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_BUCKET: if (bu_done) state_next = ST_HEAD;
            ST_HEAD:
            begin
                if (act_reg == ACT_INSERT || head_q >= NO_ENTRY)
                    state_next = ST_DONE;
                else
                    state_next = ST_WALK;
            end
            ST_WALK: if (hit || link_q >= NO_ENTRY) state_next = ST_DONE;
            ST_DONE: if (leave_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        sweep_next      = sweep_reg;
        reply_next      = reply_reg;
        act_next        = act_reg;
        name_next       = name_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        head_we         = 1'b0;
        head_wa         = bucket;
        head_wd         = cnt_reg;
        ent_we          = 1'b0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                head_we    = 1'b1;
                head_wa    = sweep_reg;
                head_wd    = NO_ENTRY;
                sweep_next = sweep_reg + BUCKET_AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next        = in_data.action;
                    name_next       = in_data.entry_name;
                    res_status_next = STAT_OK;
                    res_idx_next    = '0;
                    if (in_data.action == ACT_INSERT && full)
                        res_status_next = STAT_FULL;
                    if (in_data.action == ACT_CLEAR)
                    begin
                        sweep_next = '0;
                        reply_next = 1'b1;
                        cnt_next   = '0;
                    end
                end
            end
            ST_BUCKET: ;
            ST_HEAD:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    // new entry goes to the front of its chain
                    head_we      = 1'b1;
                    ent_we       = 1'b1;
                    res_idx_next = cnt_wide[IDX_W-1:0];
                    cnt_next     = cnt_reg + LW'(1);
                end
                else
                begin
                    cur_next = head_q;
                    if (head_q >= NO_ENTRY)
                        res_status_next = STAT_MISS;
                end
            end
            ST_WALK:
            begin
                if (hit)
                    res_idx_next = cur_wide[IDX_W-1:0];
                else if (link_q >= NO_ENTRY)
                    res_status_next = STAT_MISS;
                else
                    cur_next = link_q;
            end
            ST_DONE:
            begin
                reply_next = 1'b0;
                if (leave_done)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = res_status_reg;
                    out_data_next.entry_index   = res_idx_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            reply_reg     <= 1'b0;
            act_reg       <= ACT_INSERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sweep_reg     <= sweep_next;
            reply_reg     <= reply_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_W'(BUCKET_DEPTH);
        else if (cfg_valid && cfg_ready)
            cfg_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        name_reg       <= name_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_q <= head_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            link_mem[cnt_reg[AW-1:0]] <= head_q;
            name_mem[cnt_reg[AW-1:0]] <= name_reg;
        end
        link_q <= link_mem[rd_addr];
        name_q <= name_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CNHT_ASSERT_IMP(a_count_bound, 1'b1, cnt_reg <= NO_ENTRY,
        "entry count past table size")
    `CNHT_ASSERT_NXT(a_insert_count, state_reg == ST_HEAD && act_reg == ACT_INSERT,
        cnt_reg == LW'($past(cnt_reg) + LW'(1)), "insert did not bump count")
    `CNHT_ASSERT_IMP(a_walk_valid, state_reg == ST_WALK, cur_reg < NO_ENTRY,
        "chain walk on empty link")
    `CNHT_ASSERT_NXT(a_full_no_write, accept && in_data.action == ACT_INSERT && full,
        state_reg == ST_DONE && res_status_reg == STAT_FULL, "full insert not dropped")

endmodule
`default_nettype wire

@@ rtl/cnht_bucket_unit.sv @@
// name hash and bucket modulo, one byte then one quotient bit per cycle
// depends on cnht_pkg and the assertion macro header
`default_nettype none
`include "chained_name_hash_table_core_defines.svh"
module cnht_bucket_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [63:0]                   name,
    input  logic [cnht_pkg::CFG_W-1:0]    divisor,
    output logic                          done,
    output logic [cnht_pkg::BUCKET_AW-1:0] bucket
);
    import cnht_pkg::*;

    bu_state_t            state_reg, state_next;
    logic [31:0]          hash_reg, hash_next;
    logic [55:0]          shift_reg, shift_next;
    logic [2:0]           step_reg, step_next;
    logic [BUCKET_AW-1:0] rem_reg, rem_next;
    logic [4:0]           bit_reg, bit_next;

    logic [7:0]           cur_c;
    logic                 hash_stop;
    logic [BUCKET_AW:0]   trial;

    assign cur_c     = fold_byte(shift_reg[7:0]);
    // byte 7 is always taken once reached
    assign hash_stop = (step_reg != 3'd7) && (cur_c == 8'h00);
    assign trial     = {rem_reg, hash_reg[31]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BU_IDLE: if (start) state_next = BU_HASH;
            BU_HASH: if (hash_stop || step_reg == 3'd7) state_next = BU_DIV;
            BU_DIV:  if (bit_reg == 5'd31) state_next = BU_DONE;
            BU_DONE: state_next = BU_IDLE;
            default: state_next = BU_IDLE;
        endcase
    end

    always_comb
    begin
        hash_next  = hash_reg;
        shift_next = shift_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            BU_IDLE:
            begin
                if (start)
                begin
                    hash_next  = {24'd0, fold_byte(name[7:0])};
                    shift_next = name[63:8];
                    step_next  = 3'd1;
                    rem_next   = '0;
                    bit_next   = '0;
                end
            end
            BU_HASH:
            begin
                if (!hash_stop)
                begin
                    if (step_reg == 3'd1)
                        hash_next = hash_reg + {hash_reg[30:0], 1'b0} + {24'd0, cur_c};
                    else
                        hash_next = {hash_reg[30:0], 1'b0} + {24'd0, cur_c};
                    shift_next = {8'd0, shift_reg[55:8]};
                    step_next  = step_reg + 3'd1;
                end
            end
            BU_DIV:
            begin
                hash_next = {hash_reg[30:0], 1'b0};
                if (trial >= divisor)
                    rem_next = BUCKET_AW'(trial - divisor);
                else
                    rem_next = trial[BUCKET_AW-1:0];
                bit_next = bit_reg + 5'd1;
            end
            BU_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BU_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg  <= hash_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done   = (state_reg == BU_DONE);
    assign bucket = rem_reg;

    `CNHT_ASSERT_IMP(a_rem_below_div, state_reg == BU_DIV, {1'b0, rem_reg} < divisor, "remainder not below divisor")
    `CNHT_ASSERT_NXT(a_done_pulse, state_reg == BU_DONE, state_reg == BU_IDLE, "done held more than one cycle")
    `CNHT_ASSERT_IMP(a_step_range, state_reg == BU_HASH, step_reg != 3'd0, "hash step out of range")

endmodule
`default_nettype wire

@@ tb/chained_name_hash_table_core_tb.sv @@
// testbench for chained_name_hash_table_core: directed and random inserts, lookups, clears
// depends on cnht_pkg and the core rtl; self-checking against an in-bench table predictor
`timescale 1ns / 100ps
module chained_name_hash_table_core_tb;
    import cnht_pkg::*;

    localparam int          ENTRY_MAX   = 4096;
    localparam int          WATCH_LIMIT = 20000;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    cnht_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    cnht_out_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // predictor state
    int          head_q [BUCKET_DEPTH];
    int          link_q [ENTRY_MAX];
    logic [63:0] name_q [ENTRY_MAX];
    int          fill_count;
    int          buckets_reg;

    cnht_out_t   pending_results[$];
    logic [63:0] known_names[$];
    int          mismatches;
    int          words_sent;
    int          results_seen;
    int          idle_cycles;
    bit          quiet;
    int          out_hold;

    chained_name_hash_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
            return c - 8'h20;
        return c;
    endfunction

    function automatic logic [31:0] name_hash(input logic [63:0] nm);
        logic [31:0] h;
        h = {24'd0, upcase(nm[7:0])};
        if (upcase(nm[15:8]) == 8'd0)
            return h;
        h = h * 3 + upcase(nm[15:8]);
        for (int k = 2; k <= 6; k++)
        begin
            if (upcase(nm[8*k +: 8]) == 8'd0)
                return h;
            h = h * 2 + upcase(nm[8*k +: 8]);
        end
        return h * 2 + upcase(nm[63:56]);
    endfunction

    function automatic bit same_name(input logic [63:0] a, input logic [63:0] b);
        for (int k = 0; k < 8; k++)
        begin
            if (upcase(a[8*k +: 8]) != upcase(b[8*k +: 8]))
                return 0;
            if (upcase(a[8*k +: 8]) == 8'd0)
                return 1;
        end
        return 1;
    endfunction

    function automatic int bucket_for(input logic [63:0] nm);
        int n;
        n = buckets_reg;
        if (n == 0)
            n = 1;
        if (n > BUCKET_DEPTH)
            n = BUCKET_DEPTH;
        return int'(name_hash(nm) % n);
    endfunction

    function automatic void empty_table();
        foreach (head_q[i])
            head_q[i] = ENTRY_MAX;
        fill_count = 0;
    endfunction

    function automatic cnht_out_t table_apply(input logic [1:0] act, input logic [63:0] nm);
        cnht_out_t r;
        int        b;
        int        cur;
        int        steps;
        r.status      = STAT_OK;
        r.entry_index = '0;
        case (act)
            ACT_INSERT:
            begin
                if (fill_count >= ENTRY_MAX)
                    r.status = STAT_FULL;
                else
                begin
                    b = bucket_for(nm);
                    name_q[fill_count] = nm;
                    link_q[fill_count] = head_q[b];
                    head_q[b] = fill_count;
                    r.entry_index = fill_count[IDX_W-1:0];
                    fill_count++;
                end
            end
            ACT_LOOKUP:
            begin
                r.status = STAT_MISS;
                cur = head_q[bucket_for(nm)];
                steps = 0;
                while (cur < ENTRY_MAX && steps < ENTRY_MAX)
                begin
                    if (same_name(name_q[cur], nm))
                    begin
                        r.status = STAT_OK;
                        r.entry_index = cur[IDX_W-1:0];
                        break;
                    end
                    cur = link_q[cur];
                    steps++;
                end
            end
            ACT_CLEAR:
                empty_table();
            default: ;
        endcase
        return r;
    endfunction

    // random name: letters of both cases, digits, punctuation near the letter range,
    // high bytes; bytes after the first nul are sometimes junk
    function automatic logic [63:0] random_name();
        logic [63:0] nm;
        int          len;
        nm = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd0;
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 5))
                0: nm[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 25));
                1: nm[8*k +: 8] = 8'h41 + 8'($urandom_range(0, 25));
                2: nm[8*k +: 8] = 8'h30 + 8'($urandom_range(0, 9));
                3: nm[8*k +: 8] = 8'h5B + 8'($urandom_range(0, 5));
                4: nm[8*k +: 8] = 8'h80 + 8'($urandom_range(0, 127));
                default: nm[8*k +: 8] = 8'($urandom_range(1, 255));
            endcase
        end
        if (len < 8)
            nm[8*len +: 8] = 8'd0;
        return nm;
    endfunction

    // same name with letter case shuffled and junk after the nul
    function automatic logic [63:0] variant_of(input logic [63:0] nm);
        logic [63:0] v;
        bit          ended;
        v = nm;
        ended = 0;
        for (int k = 0; k < 8; k++)
        begin
            if (ended)
                v[8*k +: 8] = 8'($urandom_range(0, 255));
            else if (v[8*k +: 8] == 8'd0)
                ended = 1;
            else if (upcase(v[8*k +: 8]) >= 8'h41 && upcase(v[8*k +: 8]) <= 8'h5A
                     && $urandom_range(0, 1))
                v[8*k + 5] = ~v[8*k + 5];
        end
        return v;
    endfunction

    task automatic send_word(input logic [1:0] act, input logic [63:0] nm);
        in_data  <= '{action: act, entry_name: nm};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(table_apply(act, nm));
        words_sent++;
        if (act == ACT_INSERT)
        begin
            known_names.push_back(nm);
            if (known_names.size() > 64)
                void'(known_names.pop_front());
        end
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_buckets(input int value);
        drain();
        cfg_data  <= value[CFG_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        buckets_reg = value & 32'h1FFF;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_word(ACT_INSERT, 64'd0);
        send_word(ACT_INSERT, {8{8'hFF}});
        send_word(ACT_INSERT, 64'h0000_0000_0000_6F66);
        send_word(ACT_INSERT, 64'h6867_6665_6463_6261);
        send_word(ACT_LOOKUP, 64'h4847_4645_4443_4241);
        send_word(ACT_LOOKUP, 64'hAB00_0000_0000_4F46);
        send_word(ACT_LOOKUP, {8{8'hFF}});
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_0000);
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_005A);
        send_word(ACT_INSERT, 64'h0000_0000_0000_6F66);
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_4F46);
        send_word(ACT_UNUSED, {8{8'hA5}});
        send_word(ACT_CLEAR, {8{8'h5A}});
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_6F66);
        send_word(ACT_INSERT, 64'h0000_0000_0000_6F66);
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_6F66);
    endtask

    // zero and oversize counts, and a count change that strands older chains
    task automatic test_bucket_limits();
        write_buckets(0);
        send_word(ACT_INSERT, 64'h0000_0000_4241_5A59);
        send_word(ACT_LOOKUP, 64'h0000_0000_6261_7A79);
        write_buckets(8191);
        send_word(ACT_INSERT, 64'h0000_0000_0000_3132);
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_3132);
        send_word(ACT_LOOKUP, 64'h0000_0000_4241_5A59);
        write_buckets(7);
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_3132);
        send_word(ACT_LOOKUP, 64'h0000_0000_0000_6F66);
        write_buckets(4096);
    endtask

    // one bucket, so every lookup walks a single chain up to 64 nodes deep
    task automatic test_long_chain();
        write_buckets(1);
        send_word(ACT_CLEAR, 64'd0);
        for (int i = 0; i < 64; i++)
            send_word(ACT_INSERT, random_name());
        for (int i = 0; i < 8; i++)
            send_word(ACT_LOOKUP, variant_of(known_names[$urandom_range(0, 63)]));
        send_word(ACT_LOOKUP, random_name());
        send_word(ACT_CLEAR, 64'd0);
    endtask

    task automatic test_random_mix();
        int settings[7] = '{1, 4096, 0, 8191, 37, 4095, 613};
        int pick;
        foreach (settings[s])
        begin
            quiet = (s == 6);
            write_buckets(settings[s]);
            for (int i = 0; i < 230; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    send_word(ACT_CLEAR, {$urandom, $urandom});
                else if (pick < 4)
                    send_word(ACT_UNUSED, {$urandom, $urandom});
                else if (pick < 45)
                    send_word(ACT_INSERT, $urandom_range(0, 2) == 0 && known_names.size() > 0
                              ? variant_of(known_names[$urandom_range(0, known_names.size()-1)])
                              : random_name());
                else if (pick < 85 && known_names.size() > 0)
                    send_word(ACT_LOOKUP,
                              variant_of(known_names[$urandom_range(0, known_names.size()-1)]));
                else
                    send_word(ACT_LOOKUP, random_name());
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d index %0d",
                             out_data.status, out_data.entry_index);
            end
            else
            begin
                cnht_out_t want;
                want = pending_results.pop_front();
                if (out_data.status !== want.status
                    || out_data.entry_index !== want.entry_index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d index %0d, got %0d %0d",
                                 want.status, want.entry_index,
                                 out_data.status, out_data.entry_index);
                end
            end
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (out_hold > 0)
            out_hold <= out_hold - 1;
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            out_hold  <= $urandom_range(0, 17);
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("watchdog expired with %0d words outstanding", pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        mismatches  = 0;
        words_sent  = 0;
        results_seen = 0;
        idle_cycles = 0;
        quiet       = 0;
        out_hold    = 0;
        buckets_reg = 4096;
        empty_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_bucket_limits();
        test_long_chain();
        test_random_mix();
        drain();

        $display("sent %0d words, checked %0d results over 8 bucket counts incl. 0 and 8191,",
                 words_sent, results_seen);
        $display("with a 64-deep single-bucket chain, clears, unused actions and case folding");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ chained_name_hash_table_core.f @@
+incdir+rtl
rtl/cnht_pkg.sv
rtl/cnht_bucket_unit.sv
rtl/chained_name_hash_table_core.sv
tb/chained_name_hash_table_core_tb.sv
